/* rtl/sot_pkg.sv */
// Shared types and codes for the stop/limit order trigger table.
// Used by sot_eval and stop_limit_order_trigger; depends on nothing.
package sot_pkg;

  // Order kinds as carried by a request and stored in the table.
  localparam logic [2:0] KIND_MKT_BUY        = 3'd0;
  localparam logic [2:0] KIND_MKT_SELL       = 3'd1;
  localparam logic [2:0] KIND_BUY_STOP       = 3'd2;
  localparam logic [2:0] KIND_BUY_LIMIT      = 3'd3;
  localparam logic [2:0] KIND_BUY_STOPLIMIT  = 3'd4;
  localparam logic [2:0] KIND_SELL_STOP      = 3'd5;
  localparam logic [2:0] KIND_SELL_LIMIT     = 3'd6;
  localparam logic [2:0] KIND_SELL_STOPLIMIT = 3'd7;

  // Request functions.
  localparam logic FUNC_PLACE = 1'b0;
  localparam logic FUNC_PRICE = 1'b1;

  // Result outcomes.
  localparam logic OUTCOME_EXEC   = 1'b0;
  localparam logic OUTCOME_REJECT = 1'b1;

  // One pending order as held in the table memory.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] stop;
    logic [31:0] limit;
    logic [23:0] shares;
    logic [15:0] tag;
  } entry_t;

  // Verdict of the trigger check on one entry.
  typedef struct packed {
    logic       fire;
    logic       sell;
    logic [2:0] kind;
  } eval_t;

  // One result item without its last flag.
  typedef struct packed {
    logic        outcome;
    logic [15:0] tag;
    logic        sell;
    logic [23:0] shares;
  } res_t;

endpackage

/* rtl/sot_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sot_eval.sv */
// Trigger check for one table entry against the current market price.
// Depends on sot_pkg for the kind codes and the eval_t verdict type.
module sot_eval
  import sot_pkg::*;
(
  input  entry_t      entry_i,
  input  logic [31:0] price_i,
  output eval_t       eval_o
);

  logic       stop_ge;
  logic       stop_le;
  logic       limit_ge;
  logic       limit_le;
  logic [2:0] kind_eff;

  // Price comparisons, all unsigned.
  assign stop_ge  = entry_i.stop >= price_i;
  assign stop_le  = entry_i.stop <= price_i;
  assign limit_ge = entry_i.limit >= price_i;
  assign limit_le = entry_i.limit <= price_i;

  // A stop-limit whose stop is hit becomes the limit order of its side.
  always_comb begin
    kind_eff = entry_i.kind;
    if (entry_i.kind == KIND_BUY_STOPLIMIT && stop_ge) begin
      kind_eff = KIND_BUY_LIMIT;
    end else if (entry_i.kind == KIND_SELL_STOPLIMIT && stop_le) begin
      kind_eff = KIND_SELL_LIMIT;
    end
  end

  // Fire decision on the (possibly converted) kind.
  always_comb begin
    eval_o.kind = kind_eff;
    eval_o.sell = (kind_eff >= KIND_SELL_STOP);
    unique case (kind_eff)
      KIND_BUY_STOP:   eval_o.fire = stop_ge;
      KIND_BUY_LIMIT:  eval_o.fire = limit_ge;
      KIND_SELL_STOP:  eval_o.fire = stop_le;
      KIND_SELL_LIMIT: eval_o.fire = limit_le;
      default:         eval_o.fire = 1'b0;
    endcase
  end

endmodule

/* rtl/stop_limit_order_trigger.sv */
// Stop/limit order trigger table: top level.
// Depends on sot_pkg, sot_ram (table memory) and sot_eval (trigger check).
//
// Usage: requests arrive on the in_valid_i/in_ready_o channel, results leave
// on out_valid_o/out_ready_i. A place request for a market order gives one
// executed result; a pending order is appended to the table and gives no
// result, or gives one rejected result when the table is full. A price
// request scans the table oldest first and emits every fired order as an
// executed result; the final result of a request carries last_o.
// A price request on an empty table does not scan. Otherwise the scan
// evaluates one entry per cycle, unless a fired entry has nowhere to go,
// through the single table read port and the shared trigger check, and
// compacts the surviving entries in place through the write port.
// in_ready_o is low for the whole scan. A stalled receiver holds one result
// in the output register and one in a holding register; further fired
// entries then wait and the scan pauses. Reset empties the table (the fill
// count goes to zero), clears the recorded price, and drops any pending
// results; no clearing pass is needed.
module stop_limit_order_trigger
  import sot_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [2:0]  order_type_i,
  input  logic [31:0] stop_level_i,
  input  logic [31:0] limit_level_i,
  input  logic [23:0] share_count_i,
  input  logic [15:0] order_tag_i,
  input  logic [31:0] market_price_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        outcome_o,
  output logic [15:0] exec_tag_o,
  output logic        sell_side_o,
  output logic [23:0] exec_shares_o,
  output logic        last_o
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] keep_q, keep_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [31:0]   price_q, price_d;
  logic          pend_valid_q, pend_valid_d;
  res_t          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  res_t          out_q, out_d;
  logic          out_last_q, out_last_d;

  logic          accept;
  logic          out_free;
  logic          advance;
  logic          scan_end;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;
  entry_t        kept;
  eval_t         verdict;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Table memory.
  sot_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared trigger check on the entry being scanned.
  sot_eval u_eval (
    .entry_i (ram_rdata),
    .price_i (price_q),
    .eval_o  (verdict)
  );

  // A surviving entry keeps any stop-limit conversion.
  always_comb begin
    kept      = ram_rdata;
    kept.kind = verdict.kind;
  end

  // The scan moves on unless a fired entry has nowhere to go.
  assign advance  = !verdict.fire || !pend_valid_q || out_free;
  assign scan_end = (CW'(idx_q) == count_q - CW'(1));

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    keep_d       = keep_q;
    idx_d        = idx_q;
    price_d      = price_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[IW-1:0];
    ram_wdata    = '{kind: order_type_i, stop: stop_level_i, limit: limit_level_i,
                     shares: share_count_i, tag: order_tag_i};
    ram_raddr    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_PRICE) begin
            price_d = market_price_i;
            idx_d   = '0;
            keep_d  = '0;
            if (count_q != '0) begin
              state_d = ST_SCAN;
            end
          end else if (order_type_i == KIND_MKT_BUY || order_type_i == KIND_MKT_SELL) begin
            pend_d       = '{outcome: OUTCOME_EXEC, tag: order_tag_i,
                             sell: (order_type_i == KIND_MKT_SELL), shares: share_count_i};
            pend_valid_d = 1'b1;
            state_d      = ST_FLUSH;
          end else if (count_q == CW'(TABLE_DEPTH)) begin
            pend_d       = '{outcome: OUTCOME_REJECT, tag: order_tag_i,
                             sell: 1'b0, shares: '0};
            pend_valid_d = 1'b1;
            state_d      = ST_FLUSH;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
      end

      ST_SCAN: begin
        ram_raddr = advance ? idx_q + IW'(1) : idx_q;
        ram_waddr = keep_q[IW-1:0];
        ram_wdata = kept;
        if (advance) begin
          if (verdict.fire) begin
            // Hand the older fired order to the output, hold the new one.
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
              out_last_d  = 1'b0;
            end
            pend_d       = '{outcome: OUTCOME_EXEC, tag: ram_rdata.tag,
                             sell: verdict.sell, shares: ram_rdata.shares};
            pend_valid_d = 1'b1;
          end else begin
            ram_we = 1'b1;
            keep_d = keep_q + CW'(1);
          end
          idx_d = idx_q + IW'(1);
          if (scan_end) begin
            count_d = keep_d;
            state_d = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        // The held result is the final one of this request.
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      keep_q       <= '0;
      idx_q        <= '0;
      price_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      keep_q       <= keep_d;
      idx_q        <= idx_d;
      price_q      <= price_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign outcome_o     = out_q.outcome;
  assign exec_tag_o    = out_q.tag;
  assign sell_side_o   = out_q.sell;
  assign exec_shares_o = out_q.shares;
  assign last_o        = out_last_q;

  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("table fill count beyond table size");

  // Compaction never writes ahead of the entry being read.
  a_keep_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (keep_q <= CW'(idx_q)))
    else $error("compaction index ahead of scan index");

  // No held result is left behind when a request completes.
  a_no_stranded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("held result left in idle state");

  // A finished scan always passes through the flush step.
  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == ST_SCAN && state_q != ST_SCAN) |-> (state_q == ST_FLUSH))
    else $error("scan left without flushing");

endmodule

/* tb/sv/tb_stop_limit_order_trigger.sv */
// Testbench for the stop/limit order trigger table (stop_limit_order_trigger).
// Depends on sot_pkg and the RTL; predicts each fill or rejection from its own
// copy of the order book and checks every result field in arrival order.
`timescale 1ns / 1ps

module tb_stop_limit_order_trigger
  import sot_pkg::*;
();

  localparam int TABLE_DEPTH = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 3 * TABLE_DEPTH + 16;

  // One result as the block should report it.
  typedef struct packed {
    logic        outcome;
    logic [15:0] tag;
    logic        sell;
    logic [23:0] shares;
    logic        last;
  } fill_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [2:0]  order_type_i;
  logic [31:0] stop_level_i;
  logic [31:0] limit_level_i;
  logic [23:0] share_count_i;
  logic [15:0] order_tag_i;
  logic [31:0] market_price_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        outcome_o;
  logic [15:0] exec_tag_o;
  logic        sell_side_o;
  logic [23:0] exec_shares_o;
  logic        last_o;

  // Predicted book and the fills still owed by the block.
  entry_t      book [TABLE_DEPTH];
  int          book_count;
  fill_t       fills_due [$];

  int          cycle_count;
  int          mismatches;
  int          stall_left;
  bit          idle_on;
  logic [31:0] price_base;
  fill_t       seen;
  fill_t       owed;

  stop_limit_order_trigger #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .order_type_i  (order_type_i),
    .stop_level_i  (stop_level_i),
    .limit_level_i (limit_level_i),
    .share_count_i (share_count_i),
    .order_tag_i   (order_tag_i),
    .market_price_i(market_price_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .outcome_o     (outcome_o),
    .exec_tag_o    (exec_tag_o),
    .sell_side_o   (sell_side_o),
    .exec_shares_o (exec_shares_o),
    .last_o        (last_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic fill_t make_fill(logic outcome, logic [15:0] tag, logic sell,
                                      logic [23:0] shares);
    fill_t f;
    f.outcome = outcome;
    f.tag     = tag;
    f.sell    = sell;
    f.shares  = shares;
    f.last    = 1'b0;
    return f;
  endfunction

  // Applies one accepted request to the predicted book and queues its fills.
  function automatic void predict_request(logic f, logic [2:0] k, logic [31:0] stp,
                                          logic [31:0] lim, logic [23:0] shr,
                                          logic [15:0] tg, logic [31:0] px);
    fill_t      pend;
    bit         have_pend;
    bit         fire;
    logic [2:0] kind;
    entry_t     slot;
    int         keep;
    have_pend = 1'b0;
    keep = 0;
    pend = '0;
    if (f == FUNC_PLACE) begin
      if (k == KIND_MKT_BUY || k == KIND_MKT_SELL) begin
        pend = make_fill(OUTCOME_EXEC, tg, k == KIND_MKT_SELL, shr);
        pend.last = 1'b1;
        fills_due.push_back(pend);
      end else if (book_count >= TABLE_DEPTH) begin
        pend = make_fill(OUTCOME_REJECT, tg, 1'b0, 24'd0);
        pend.last = 1'b1;
        fills_due.push_back(pend);
      end else begin
        slot.kind   = k;
        slot.stop   = stp;
        slot.limit  = lim;
        slot.shares = shr;
        slot.tag    = tg;
        book[book_count] = slot;
        book_count++;
      end
    end else begin
      // Scan oldest first; a stop-limit whose stop is hit is rechecked as a limit.
      for (int i = 0; i < book_count; i++) begin
        kind = book[i].kind;
        if (kind == KIND_BUY_STOPLIMIT && book[i].stop >= px) kind = KIND_BUY_LIMIT;
        else if (kind == KIND_SELL_STOPLIMIT && book[i].stop <= px) kind = KIND_SELL_LIMIT;
        book[i].kind = kind;
        case (kind)
          KIND_BUY_STOP:   fire = book[i].stop >= px;
          KIND_BUY_LIMIT:  fire = book[i].limit >= px;
          KIND_SELL_STOP:  fire = book[i].stop <= px;
          KIND_SELL_LIMIT: fire = book[i].limit <= px;
          default:         fire = 1'b0;
        endcase
        if (fire) begin
          if (have_pend) fills_due.push_back(pend);
          pend = make_fill(OUTCOME_EXEC, book[i].tag, kind >= KIND_SELL_STOP, book[i].shares);
          have_pend = 1'b1;
        end else begin
          book[keep] = book[i];
          keep++;
        end
      end
      book_count = keep;
      if (have_pend) begin
        pend.last = 1'b1;
        fills_due.push_back(pend);
      end
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Compares one delivered result with the oldest owed fill.
  task automatic check_fill();
    seen.outcome = outcome_o;
    seen.tag     = exec_tag_o;
    seen.sell    = sell_side_o;
    seen.shares  = exec_shares_o;
    seen.last    = last_o;
    if (fills_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result with tag %h", seen.tag));
    end else begin
      owed = fills_due.pop_front();
      if (seen.outcome !== owed.outcome)
        report_mismatch($sformatf("outcome %b, expected %b", seen.outcome, owed.outcome));
      if (seen.tag !== owed.tag)
        report_mismatch($sformatf("exec_tag %h, expected %h", seen.tag, owed.tag));
      if (seen.sell !== owed.sell)
        report_mismatch($sformatf("sell_side %b, expected %b (tag %h)", seen.sell, owed.sell,
                                  owed.tag));
      if (seen.shares !== owed.shares)
        report_mismatch($sformatf("exec_shares %h, expected %h (tag %h)", seen.shares,
                                  owed.shares, owed.tag));
      if (seen.last !== owed.last)
        report_mismatch($sformatf("last %b, expected %b (tag %h)", seen.last, owed.last,
                                  owed.tag));
    end
  endtask

  // Watches both handshakes, drives receiver stalls and enforces the cycle limit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL stop_limit_order_trigger");
        $finish;
      end else begin
        if (out_valid_o && out_ready_i) check_fill();
        if (in_valid_i && in_ready_o)
          predict_request(func_i, order_type_i, stop_level_i, limit_level_i, share_count_i,
                          order_tag_i, market_price_i);
        if (stall_left != 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(0, 2);
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Sends one request and returns at the edge where it is accepted.
  task automatic send_request(logic f, logic [2:0] k, logic [31:0] stp, logic [31:0] lim,
                              logic [23:0] shr, logic [15:0] tg, logic [31:0] px);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    func_i         <= f;
    order_type_i   <= k;
    stop_level_i   <= stp;
    limit_level_i  <= lim;
    share_count_i  <= shr;
    order_tag_i    <= tg;
    market_price_i <= px;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic place_order(logic [2:0] k, logic [31:0] stp, logic [31:0] lim,
                             logic [15:0] tg);
    send_request(FUNC_PLACE, k, stp, lim, 24'($urandom_range(1, 24'hFFFFFF)), tg,
                 $urandom());
  endtask

  task automatic post_price(logic [31:0] px);
    send_request(FUNC_PRICE, 3'($urandom_range(0, 7)), $urandom(), $urandom(),
                 24'($urandom_range(0, 24'hFFFFFF)), 16'($urandom()), px);
  endtask

  // Holds the sender back until every owed fill has been delivered.
  task automatic wait_for_fills();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (fills_due.size() != 0);
  endtask

  // Levels mostly cluster around the moving price so that orders do fire.
  function automatic logic [31:0] rand_level();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'd0;
      2:       return 32'hFFFF_FFFF;
      default: return price_base + $urandom_range(0, 600) - 300;
    endcase
  endfunction

  task automatic send_random_item();
    logic [31:0] px;
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 11))
        0:       px = $urandom();
        1:       px = 32'd0;
        2:       px = 32'hFFFF_FFFF;
        default: begin
          price_base = price_base + $urandom_range(0, 400) - 200;
          px = price_base;
        end
      endcase
      post_price(px);
    end else begin
      place_order(3'($urandom_range(0, 7)), rand_level(), rand_level(), 16'($urandom()));
    end
  endtask

  // Market orders execute at once; price requests on an empty book give nothing.
  task automatic test_market_orders();
    send_request(FUNC_PLACE, KIND_MKT_BUY, $urandom(), $urandom(), 24'd1, 16'h0000,
                 $urandom());
    send_request(FUNC_PLACE, KIND_MKT_SELL, $urandom(), $urandom(), 24'hFFFFFF, 16'hFFFF,
                 $urandom());
    place_order(KIND_MKT_SELL, $urandom(), $urandom(), 16'($urandom()));
    post_price(32'd0);
    post_price(32'hFFFF_FFFF);
  endtask

  // Each trigger rule at, just past and short of its level, with stop-limit conversion.
  task automatic test_trigger_rules();
    place_order(KIND_BUY_STOP,       32'd1000, $urandom(), 16'h0101);
    place_order(KIND_BUY_LIMIT,      $urandom(), 32'd1000, 16'h0102);
    place_order(KIND_SELL_STOP,      32'd1000, $urandom(), 16'h0103);
    place_order(KIND_SELL_LIMIT,     $urandom(), 32'd1000, 16'h0104);
    place_order(KIND_BUY_STOPLIMIT,  32'd1000, 32'd500,  16'h0105);
    place_order(KIND_SELL_STOPLIMIT, 32'd1000, 32'd1500, 16'h0106);
    place_order(KIND_BUY_STOPLIMIT,  32'd999,  32'd2000, 16'h0107);
    place_order(KIND_SELL_STOP,      32'd1001, $urandom(), 16'h0108);
    post_price(32'd1000);
    post_price(32'd500);
    post_price(32'd1500);
  endtask

  // Levels at the ends of the unsigned range.
  task automatic test_level_extremes();
    place_order(KIND_BUY_STOP,   32'hFFFF_FFFF, $urandom(), 16'h0201);
    place_order(KIND_SELL_STOP,  32'd0, $urandom(), 16'h0202);
    place_order(KIND_BUY_LIMIT,  $urandom(), 32'd0, 16'h0203);
    place_order(KIND_SELL_LIMIT, $urandom(), 32'hFFFF_FFFF, 16'h0204);
    post_price(32'hFFFF_FFFF);
    post_price(32'd0);
  endtask

  // Fill the book, get rejections and a market fill, then fire every entry at once.
  task automatic test_full_table();
    int         room;
    logic [2:0] k;
    wait_for_fills();
    room = TABLE_DEPTH - book_count;
    for (int i = 0; i < room; i++) begin
      k = 3'($urandom_range(KIND_BUY_STOP, KIND_SELL_STOPLIMIT));
      if (k >= KIND_SELL_STOP)
        place_order(k, $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h7FFF_FFFF),
                    16'($urandom()));
      else
        place_order(k, 32'hF000_0000 | $urandom_range(0, 32'h0FFF_FFFF),
                    32'hF000_0000 | $urandom_range(0, 32'h0FFF_FFFF), 16'($urandom()));
    end
    place_order(3'($urandom_range(KIND_BUY_STOP, KIND_SELL_STOPLIMIT)), $urandom(),
                $urandom(), 16'($urandom()));
    place_order(KIND_SELL_STOPLIMIT, $urandom(), $urandom(), 16'($urandom()));
    place_order(KIND_MKT_SELL, $urandom(), $urandom(), 16'($urandom()));
    post_price(32'h8000_0000);
  endtask

  // Random mix of placements and price moves, with one full drain halfway.
  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_fills();
      send_random_item();
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream(int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) send_random_item();
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    func_i         <= FUNC_PLACE;
    order_type_i   <= KIND_MKT_BUY;
    stop_level_i   <= '0;
    limit_level_i  <= '0;
    share_count_i  <= '0;
    order_tag_i    <= '0;
    market_price_i <= '0;
    out_ready_i    <= 1'b0;
    book_count  = 0;
    cycle_count = 0;
    mismatches  = 0;
    stall_left  = 0;
    idle_on     = 1'b1;
    price_base  = 32'd100000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_market_orders();
    test_trigger_rules();
    test_level_extremes();
    test_full_table();
    test_random_mix(120);
    test_steady_stream(40);

    // Let the last scan finish and catch any stray results.
    wait_for_fills();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS stop_limit_order_trigger");
    end else begin
      $display("FAIL stop_limit_order_trigger");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sot_pkg.sv
rtl/sot_ram.sv
rtl/sot_eval.sv
rtl/stop_limit_order_trigger.sv
tb/sv/tb_stop_limit_order_trigger.sv
